[hdl/m4inv_pkg.sv]
// Shared types, constants and saturating arithmetic for the 4x4 matrix inverse.
// Holds the adjugate microprogram that the back end steps through.
// No dependencies.
package m4inv_pkg;

  localparam int FracBits  = 16;
  localparam int RecipBits = 63 - FracBits;
  localparam int NumElems  = 16;
  localparam int ElemW     = 32;
  localparam int ValW      = 64;
  localparam int RfDepth   = 46;
  localparam int RfAw      = 6;
  localparam int ProgLen   = 79;
  localparam int PcW       = 7;
  localparam int AdjBase   = 30;
  localparam int DetAddr   = 29;

  typedef logic [NumElems-1:0][ElemW-1:0] matrix_t;
  typedef logic signed [ValW-1:0] val_t;

  localparam val_t MaxVal = {1'b0, {(ValW-1){1'b1}}};
  localparam val_t MinVal = {1'b1, {(ValW-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LD,
    OP_MAC,
    OP_MSC,
    OP_ADDR
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [RfAw-1:0] ra;
    logic [RfAw-1:0] rb;
    logic            st;
    logic            ng;
    logic [RfAw-1:0] dst;
  } instr_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_FILL,
    B_RD,
    B_OPS,
    B_MUL,
    B_WB,
    B_DSET,
    B_DIV,
    B_ORD,
    B_OST,
    B_OMUL,
    B_OUT
  } back_state_e;

  typedef enum logic [1:0] {
    M_IDLE,
    M_PROD,
    M_RND,
    M_SAT
  } mul_state_e;

  typedef struct packed {
    logic            start;
    logic [ValW-1:0] a;
    logic [ValW-1:0] b;
    logic            neg;
    logic            long_shift;
  } mul_req_t;

  typedef struct packed {
    logic done;
    val_t res;
  } mul_rsp_t;

  typedef struct packed {
    logic    push;
    matrix_t data;
  } q_push_t;

  function automatic val_t sadd(val_t a, val_t b);
    logic [ValW:0] s;
    s = {a[ValW-1], a} + {b[ValW-1], b};
    if (s[ValW] != s[ValW-1]) begin
      return s[ValW] ? MinVal : MaxVal;
    end
    return s[ValW-1:0];
  endfunction

  function automatic val_t sneg(val_t a);
    if (a == MinVal) begin
      return MaxVal;
    end
    return ~a + val_t'(1);
  endfunction

  function automatic val_t ssub(val_t a, val_t b);
    return sadd(a, sneg(b));
  endfunction

  function automatic logic [ValW-1:0] mag(val_t a);
    return a[ValW-1] ? (~a + 64'd1) : a;
  endfunction

  function automatic logic [ElemW-1:0] sat32(val_t a);
    if (a[ValW-1:ElemW-1] != {(ValW-ElemW+1){a[ValW-1]}}) begin
      return a[ValW-1] ? {1'b1, {(ElemW-1){1'b0}}} : {1'b0, {(ElemW-1){1'b1}}};
    end
    return a[ElemW-1:0];
  endfunction

  function automatic instr_t ins(op_e op, logic [RfAw-1:0] ra, logic [RfAw-1:0] rb,
                                 logic st, logic ng, logic [RfAw-1:0] dst);
    instr_t r;
    r.op  = op;
    r.ra  = ra;
    r.rb  = rb;
    r.st  = st;
    r.ng  = ng;
    r.dst = dst;
    return r;
  endfunction

  // Scratch map: elements 0..15 (row*4+col), s 16..18, t 19..21, u 22..24,
  // v 25..27, dot(t,u) 28, det 29, adjugate 30..45 row-major.
  function automatic instr_t prog(logic [PcW-1:0] pc);
    instr_t p;
    case (pc)
      7'd0:  p = ins(OP_LD,   6'd4,  6'd9,  1'b0, 1'b0, 6'd0);
      7'd1:  p = ins(OP_MSC,  6'd8,  6'd5,  1'b1, 1'b0, 6'd16);
      7'd2:  p = ins(OP_LD,   6'd8,  6'd1,  1'b0, 1'b0, 6'd0);
      7'd3:  p = ins(OP_MSC,  6'd0,  6'd9,  1'b1, 1'b0, 6'd17);
      7'd4:  p = ins(OP_LD,   6'd0,  6'd5,  1'b0, 1'b0, 6'd0);
      7'd5:  p = ins(OP_MSC,  6'd4,  6'd1,  1'b1, 1'b0, 6'd18);
      7'd6:  p = ins(OP_LD,   6'd6,  6'd11, 1'b0, 1'b0, 6'd0);
      7'd7:  p = ins(OP_MSC,  6'd10, 6'd7,  1'b1, 1'b0, 6'd19);
      7'd8:  p = ins(OP_LD,   6'd10, 6'd3,  1'b0, 1'b0, 6'd0);
      7'd9:  p = ins(OP_MSC,  6'd2,  6'd11, 1'b1, 1'b0, 6'd20);
      7'd10: p = ins(OP_LD,   6'd2,  6'd7,  1'b0, 1'b0, 6'd0);
      7'd11: p = ins(OP_MSC,  6'd6,  6'd3,  1'b1, 1'b0, 6'd21);
      7'd12: p = ins(OP_LD,   6'd0,  6'd13, 1'b0, 1'b0, 6'd0);
      7'd13: p = ins(OP_MSC,  6'd1,  6'd12, 1'b1, 1'b0, 6'd22);
      7'd14: p = ins(OP_LD,   6'd4,  6'd13, 1'b0, 1'b0, 6'd0);
      7'd15: p = ins(OP_MSC,  6'd5,  6'd12, 1'b1, 1'b0, 6'd23);
      7'd16: p = ins(OP_LD,   6'd8,  6'd13, 1'b0, 1'b0, 6'd0);
      7'd17: p = ins(OP_MSC,  6'd9,  6'd12, 1'b1, 1'b0, 6'd24);
      7'd18: p = ins(OP_LD,   6'd2,  6'd15, 1'b0, 1'b0, 6'd0);
      7'd19: p = ins(OP_MSC,  6'd3,  6'd14, 1'b1, 1'b0, 6'd25);
      7'd20: p = ins(OP_LD,   6'd6,  6'd15, 1'b0, 1'b0, 6'd0);
      7'd21: p = ins(OP_MSC,  6'd7,  6'd14, 1'b1, 1'b0, 6'd26);
      7'd22: p = ins(OP_LD,   6'd10, 6'd15, 1'b0, 1'b0, 6'd0);
      7'd23: p = ins(OP_MSC,  6'd11, 6'd14, 1'b1, 1'b0, 6'd27);
      7'd24: p = ins(OP_LD,   6'd19, 6'd22, 1'b0, 1'b0, 6'd0);
      7'd25: p = ins(OP_MAC,  6'd20, 6'd23, 1'b0, 1'b0, 6'd0);
      7'd26: p = ins(OP_MAC,  6'd21, 6'd24, 1'b1, 1'b0, 6'd28);
      7'd27: p = ins(OP_LD,   6'd16, 6'd25, 1'b0, 1'b0, 6'd0);
      7'd28: p = ins(OP_MAC,  6'd17, 6'd26, 1'b0, 1'b0, 6'd0);
      7'd29: p = ins(OP_MAC,  6'd18, 6'd27, 1'b0, 1'b0, 6'd0);
      7'd30: p = ins(OP_ADDR, 6'd0,  6'd28, 1'b1, 1'b0, 6'd29);
      7'd31: p = ins(OP_LD,   6'd5,  6'd27, 1'b0, 1'b0, 6'd0);
      7'd32: p = ins(OP_MSC,  6'd9,  6'd26, 1'b0, 1'b0, 6'd0);
      7'd33: p = ins(OP_MAC,  6'd19, 6'd13, 1'b1, 1'b0, 6'd30);
      7'd34: p = ins(OP_LD,   6'd9,  6'd25, 1'b0, 1'b0, 6'd0);
      7'd35: p = ins(OP_MSC,  6'd1,  6'd27, 1'b0, 1'b0, 6'd0);
      7'd36: p = ins(OP_MAC,  6'd20, 6'd13, 1'b1, 1'b0, 6'd31);
      7'd37: p = ins(OP_LD,   6'd1,  6'd26, 1'b0, 1'b0, 6'd0);
      7'd38: p = ins(OP_MSC,  6'd5,  6'd25, 1'b0, 1'b0, 6'd0);
      7'd39: p = ins(OP_MAC,  6'd21, 6'd13, 1'b1, 1'b0, 6'd32);
      7'd40: p = ins(OP_LD,   6'd1,  6'd19, 1'b0, 1'b0, 6'd0);
      7'd41: p = ins(OP_MAC,  6'd5,  6'd20, 1'b0, 1'b0, 6'd0);
      7'd42: p = ins(OP_MAC,  6'd9,  6'd21, 1'b1, 1'b1, 6'd33);
      7'd43: p = ins(OP_LD,   6'd26, 6'd8,  1'b0, 1'b0, 6'd0);
      7'd44: p = ins(OP_MSC,  6'd27, 6'd4,  1'b0, 1'b0, 6'd0);
      7'd45: p = ins(OP_MSC,  6'd19, 6'd12, 1'b1, 1'b0, 6'd34);
      7'd46: p = ins(OP_LD,   6'd27, 6'd0,  1'b0, 1'b0, 6'd0);
      7'd47: p = ins(OP_MSC,  6'd25, 6'd8,  1'b0, 1'b0, 6'd0);
      7'd48: p = ins(OP_MSC,  6'd20, 6'd12, 1'b1, 1'b0, 6'd35);
      7'd49: p = ins(OP_LD,   6'd25, 6'd4,  1'b0, 1'b0, 6'd0);
      7'd50: p = ins(OP_MSC,  6'd26, 6'd0,  1'b0, 1'b0, 6'd0);
      7'd51: p = ins(OP_MSC,  6'd21, 6'd12, 1'b1, 1'b0, 6'd36);
      7'd52: p = ins(OP_LD,   6'd0,  6'd19, 1'b0, 1'b0, 6'd0);
      7'd53: p = ins(OP_MAC,  6'd4,  6'd20, 1'b0, 1'b0, 6'd0);
      7'd54: p = ins(OP_MAC,  6'd8,  6'd21, 1'b1, 1'b0, 6'd37);
      7'd55: p = ins(OP_LD,   6'd7,  6'd24, 1'b0, 1'b0, 6'd0);
      7'd56: p = ins(OP_MSC,  6'd11, 6'd23, 1'b0, 1'b0, 6'd0);
      7'd57: p = ins(OP_MAC,  6'd16, 6'd15, 1'b1, 1'b0, 6'd38);
      7'd58: p = ins(OP_LD,   6'd11, 6'd22, 1'b0, 1'b0, 6'd0);
      7'd59: p = ins(OP_MSC,  6'd3,  6'd24, 1'b0, 1'b0, 6'd0);
      7'd60: p = ins(OP_MAC,  6'd17, 6'd15, 1'b1, 1'b0, 6'd39);
      7'd61: p = ins(OP_LD,   6'd3,  6'd23, 1'b0, 1'b0, 6'd0);
      7'd62: p = ins(OP_MSC,  6'd7,  6'd22, 1'b0, 1'b0, 6'd0);
      7'd63: p = ins(OP_MAC,  6'd18, 6'd15, 1'b1, 1'b0, 6'd40);
      7'd64: p = ins(OP_LD,   6'd3,  6'd16, 1'b0, 1'b0, 6'd0);
      7'd65: p = ins(OP_MAC,  6'd7,  6'd17, 1'b0, 1'b0, 6'd0);
      7'd66: p = ins(OP_MAC,  6'd11, 6'd18, 1'b1, 1'b1, 6'd41);
      7'd67: p = ins(OP_LD,   6'd23, 6'd10, 1'b0, 1'b0, 6'd0);
      7'd68: p = ins(OP_MSC,  6'd24, 6'd6,  1'b0, 1'b0, 6'd0);
      7'd69: p = ins(OP_MSC,  6'd16, 6'd14, 1'b1, 1'b0, 6'd42);
      7'd70: p = ins(OP_LD,   6'd24, 6'd2,  1'b0, 1'b0, 6'd0);
      7'd71: p = ins(OP_MSC,  6'd22, 6'd10, 1'b0, 1'b0, 6'd0);
      7'd72: p = ins(OP_MSC,  6'd17, 6'd14, 1'b1, 1'b0, 6'd43);
      7'd73: p = ins(OP_LD,   6'd22, 6'd6,  1'b0, 1'b0, 6'd0);
      7'd74: p = ins(OP_MSC,  6'd23, 6'd2,  1'b0, 1'b0, 6'd0);
      7'd75: p = ins(OP_MSC,  6'd18, 6'd14, 1'b1, 1'b0, 6'd44);
      7'd76: p = ins(OP_LD,   6'd2,  6'd16, 1'b0, 1'b0, 6'd0);
      7'd77: p = ins(OP_MAC,  6'd6,  6'd17, 1'b0, 1'b0, 6'd0);
      7'd78: p = ins(OP_MAC,  6'd10, 6'd18, 1'b1, 1'b0, 6'd45);
      default: p = ins(OP_LD, 6'd0, 6'd0, 1'b0, 1'b0, 6'd0);
    endcase
    return p;
  endfunction

endpackage

[hdl/m4inv_front.sv]
// Front end: element store, load position and hand-off of complete matrices.
// Depends on m4inv_pkg.
module m4inv_front (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic signed [m4inv_pkg::ElemW-1:0]        element_value_i,
  input  logic                                      last_element_i,
  input  logic                                      q_ready_i,
  output m4inv_pkg::q_push_t                        q_push_o
);

  m4inv_pkg::matrix_t store_q, store_d;
  logic [3:0]         pos_q, pos_d;
  logic               accept;

  // hold a last beat until the queue has room
  assign in_ready_o = !last_element_i || q_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    store_d        = store_q;
    store_d[pos_q] = element_value_i;
    pos_d          = last_element_i ? 4'd0 : pos_q + 4'd1;
  end

  assign q_push_o.push = accept && last_element_i;
  assign q_push_o.data = store_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      pos_q   <= '0;
    end else if (accept) begin
      store_q <= store_d;
      pos_q   <= pos_d;
    end
  end

endmodule

[hdl/m4inv_queue.sv]
// Two-entry queue of loaded matrices between the front and back ends.
// Depends on m4inv_pkg.
module m4inv_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  m4inv_pkg::q_push_t push_i,
  output logic               ready_o,
  output logic               valid_o,
  output m4inv_pkg::matrix_t data_o,
  input  logic               pop_i
);

  m4inv_pkg::matrix_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wp_q] <= push_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i.push) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i.push} - {1'b0, pop_i};
    end
  end

endmodule

[hdl/m4inv_mul.sv]
// Shared 64x64 magnitude multiplier: four 32x32 partial products, then
// rounding half away from zero and saturation. Depends on m4inv_pkg.
module m4inv_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  m4inv_pkg::mul_req_t req_i,
  output m4inv_pkg::mul_rsp_t rsp_o
);

  localparam logic [127:0] HalfF = 128'(1) << (m4inv_pkg::FracBits - 1);
  localparam logic [127:0] HalfP = 128'(1) << (m4inv_pkg::RecipBits - 1);

  m4inv_pkg::mul_state_e state_q, state_d;
  logic [63:0]  a_q, a_d, b_q, b_d;
  logic         neg_q, neg_d, long_q, long_d;
  logic [2:0]   step_q, step_d, prev;
  logic [1:0]   pos;
  logic [63:0]  prod_q, prod_d;
  logic [127:0] acc_q, acc_d, rnd_q, rnd_d;
  logic [31:0]  a_half, b_half;
  m4inv_pkg::val_t res_q, res_d;
  logic         done_q, done_d;

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    neg_d   = neg_q;
    long_d  = long_q;
    step_d  = step_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    rnd_d   = rnd_q;
    res_d   = res_q;
    done_d  = 1'b0;
    a_half  = step_q[1] ? a_q[63:32] : a_q[31:0];
    b_half  = step_q[0] ? b_q[63:32] : b_q[31:0];
    prev    = step_q - 3'd1;
    pos     = {1'b0, prev[1]} + {1'b0, prev[0]};
    case (state_q)
      m4inv_pkg::M_IDLE: begin
        if (req_i.start) begin
          a_d     = req_i.a;
          b_d     = req_i.b;
          neg_d   = req_i.neg;
          long_d  = req_i.long_shift;
          step_d  = '0;
          acc_d   = '0;
          state_d = m4inv_pkg::M_PROD;
        end
      end
      m4inv_pkg::M_PROD: begin
        prod_d = a_half * b_half;
        if (step_q != 3'd0) begin
          acc_d = acc_q + ({64'd0, prod_q} << {pos, 5'd0});
        end
        step_d = step_q + 3'd1;
        if (step_q == 3'd4) state_d = m4inv_pkg::M_RND;
      end
      m4inv_pkg::M_RND: begin
        rnd_d   = long_q ? (acc_q + HalfP) >> m4inv_pkg::RecipBits
                         : (acc_q + HalfF) >> m4inv_pkg::FracBits;
        state_d = m4inv_pkg::M_SAT;
      end
      m4inv_pkg::M_SAT: begin
        if (rnd_q[127:63] != '0) begin
          res_d = neg_q ? m4inv_pkg::MinVal : m4inv_pkg::MaxVal;
        end else begin
          res_d = neg_q ? ~rnd_q[63:0] + 64'd1 : rnd_q[63:0];
        end
        done_d  = 1'b1;
        state_d = m4inv_pkg::M_IDLE;
      end
      default: state_d = m4inv_pkg::M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= m4inv_pkg::M_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    neg_q  <= neg_d;
    long_q <= long_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    rnd_q  <= rnd_d;
    res_q  <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

[hdl/m4inv_back.sv]
// Back end: scratch memory, adjugate sequencer, reciprocal divider and
// output register. Depends on m4inv_pkg; drives the shared m4inv_mul.
module m4inv_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  input  m4inv_pkg::matrix_t                 q_data_i,
  output logic                               q_pop_o,
  output m4inv_pkg::mul_req_t                mul_req_o,
  input  m4inv_pkg::mul_rsp_t                mul_rsp_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [m4inv_pkg::ElemW-1:0] inverse_value_o,
  output logic [1:0]                         out_row_o,
  output logic [1:0]                         out_col_o,
  output logic                               singular_o,
  output logic                               last_result_o
);

  m4inv_pkg::back_state_e state_q, state_d;
  m4inv_pkg::instr_t      instr;
  m4inv_pkg::val_t        rf_mem [m4inv_pkg::RfDepth];
  m4inv_pkg::val_t        rd_a_q, rd_b_q, wdata;
  logic [m4inv_pkg::RfAw-1:0] ra_sel, rb_sel, waddr;
  logic                   we;

  logic [3:0]                  idx_q, idx_d, k_q, k_d;
  logic [m4inv_pkg::PcW-1:0]   pc_q, pc_d;
  m4inv_pkg::val_t             acc_q, acc_d, det_q, det_d;
  logic [63:0]                 recip_q, recip_d, rem_q, rem_d, num_q, num_d, den_q, den_d;
  logic [64:0]                 trial;
  logic [5:0]                  dcnt_q, dcnt_d;
  logic                        sing_q, sing_d;
  logic [31:0]                 res32_q, res32_d;

  logic        ov_q, ov_d, os_q, os_d, ol_q, ol_d;
  logic [31:0] oval_q, oval_d;
  logic [1:0]  orow_q, orow_d, ocol_q, ocol_d;

  assign instr = m4inv_pkg::prog(pc_q);
  assign trial = {rem_q, num_q[63]};

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    k_d       = k_q;
    pc_d      = pc_q;
    acc_d     = acc_q;
    det_d     = det_q;
    recip_d   = recip_q;
    rem_d     = rem_q;
    num_d     = num_q;
    den_d     = den_q;
    dcnt_d    = dcnt_q;
    sing_d    = sing_q;
    res32_d   = res32_q;
    ov_d      = ov_q && !out_ready_i;
    os_d      = os_q;
    ol_d      = ol_q;
    oval_d    = oval_q;
    orow_d    = orow_q;
    ocol_d    = ocol_q;
    we        = 1'b0;
    waddr     = {2'b00, idx_q};
    wdata     = '0;
    ra_sel    = instr.ra;
    rb_sel    = instr.rb;
    q_pop_o   = 1'b0;
    mul_req_o.start      = 1'b0;
    mul_req_o.a          = m4inv_pkg::mag(rd_a_q);
    mul_req_o.b          = m4inv_pkg::mag(rd_b_q);
    mul_req_o.neg        = rd_a_q[63] ^ rd_b_q[63];
    mul_req_o.long_shift = 1'b0;
    case (state_q)
      m4inv_pkg::B_IDLE: begin
        if (q_valid_i) begin
          idx_d   = '0;
          state_d = m4inv_pkg::B_FILL;
        end
      end
      m4inv_pkg::B_FILL: begin
        we    = 1'b1;
        wdata = {{32{q_data_i[idx_q][31]}}, q_data_i[idx_q]};
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd15) begin
          q_pop_o = 1'b1;
          pc_d    = '0;
          state_d = m4inv_pkg::B_RD;
        end
      end
      m4inv_pkg::B_RD: state_d = m4inv_pkg::B_OPS;
      m4inv_pkg::B_OPS: begin
        if (instr.op == m4inv_pkg::OP_ADDR) begin
          acc_d   = m4inv_pkg::sadd(acc_q, rd_b_q);
          state_d = m4inv_pkg::B_WB;
        end else begin
          mul_req_o.start = 1'b1;
          state_d         = m4inv_pkg::B_MUL;
        end
      end
      m4inv_pkg::B_MUL: begin
        if (mul_rsp_i.done) begin
          case (instr.op)
            m4inv_pkg::OP_LD:  acc_d = mul_rsp_i.res;
            m4inv_pkg::OP_MAC: acc_d = m4inv_pkg::sadd(acc_q, mul_rsp_i.res);
            m4inv_pkg::OP_MSC: acc_d = m4inv_pkg::ssub(acc_q, mul_rsp_i.res);
            default:           acc_d = acc_q;
          endcase
          state_d = m4inv_pkg::B_WB;
        end
      end
      m4inv_pkg::B_WB: begin
        waddr = instr.dst;
        wdata = instr.ng ? m4inv_pkg::sneg(acc_q) : acc_q;
        if (instr.st) begin
          we = 1'b1;
          if (instr.dst == m4inv_pkg::RfAw'(m4inv_pkg::DetAddr)) det_d = wdata;
        end
        pc_d    = pc_q + m4inv_pkg::PcW'(1);
        state_d = (pc_q == m4inv_pkg::PcW'(m4inv_pkg::ProgLen - 1)) ?
                  m4inv_pkg::B_DSET : m4inv_pkg::B_RD;
      end
      m4inv_pkg::B_DSET: begin
        sing_d  = (det_q == '0);
        den_d   = m4inv_pkg::mag(det_q);
        num_d   = {1'b1, 63'd0} + {1'b0, den_d[63:1]};
        rem_d   = '0;
        recip_d = '0;
        dcnt_d  = '0;
        k_d     = '0;
        state_d = (det_q == '0) ? m4inv_pkg::B_ORD : m4inv_pkg::B_DIV;
      end
      m4inv_pkg::B_DIV: begin
        if (trial >= {1'b0, den_q}) begin
          rem_d   = 64'(trial - {1'b0, den_q});
          recip_d = {recip_q[62:0], 1'b1};
        end else begin
          rem_d   = trial[63:0];
          recip_d = {recip_q[62:0], 1'b0};
        end
        num_d  = {num_q[62:0], 1'b0};
        dcnt_d = dcnt_q + 6'd1;
        if (dcnt_q == 6'd63) state_d = m4inv_pkg::B_ORD;
      end
      m4inv_pkg::B_ORD: begin
        ra_sel  = m4inv_pkg::RfAw'(m4inv_pkg::AdjBase) + {2'b00, k_q};
        state_d = m4inv_pkg::B_OST;
      end
      m4inv_pkg::B_OST: begin
        if (sing_q) begin
          res32_d = '0;
          state_d = m4inv_pkg::B_OUT;
        end else begin
          mul_req_o.start      = 1'b1;
          mul_req_o.b          = recip_q;
          mul_req_o.neg        = rd_a_q[63] ^ det_q[63];
          mul_req_o.long_shift = 1'b1;
          state_d              = m4inv_pkg::B_OMUL;
        end
      end
      m4inv_pkg::B_OMUL: begin
        if (mul_rsp_i.done) begin
          res32_d = m4inv_pkg::sat32(mul_rsp_i.res);
          state_d = m4inv_pkg::B_OUT;
        end
      end
      m4inv_pkg::B_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          oval_d  = res32_q;
          orow_d  = k_q[3:2];
          ocol_d  = k_q[1:0];
          os_d    = sing_q;
          ol_d    = (k_q == 4'd15);
          k_d     = k_q + 4'd1;
          state_d = (k_q == 4'd15) ? m4inv_pkg::B_IDLE : m4inv_pkg::B_ORD;
        end
      end
      default: state_d = m4inv_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) rf_mem[waddr] <= wdata;
    rd_a_q <= rf_mem[ra_sel];
    rd_b_q <= rf_mem[rb_sel];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= m4inv_pkg::B_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    k_q     <= k_d;
    pc_q    <= pc_d;
    acc_q   <= acc_d;
    det_q   <= det_d;
    recip_q <= recip_d;
    rem_q   <= rem_d;
    num_q   <= num_d;
    den_q   <= den_d;
    dcnt_q  <= dcnt_d;
    sing_q  <= sing_d;
    res32_q <= res32_d;
    oval_q  <= oval_d;
    orow_q  <= orow_d;
    ocol_q  <= ocol_d;
    os_q    <= os_d;
    ol_q    <= ol_d;
  end

  assign out_valid_o     = ov_q;
  assign inverse_value_o = oval_q;
  assign out_row_o       = orow_q;
  assign out_col_o       = ocol_q;
  assign singular_o      = os_q;
  assign last_result_o   = ol_q;

endmodule

[hdl/matrix4_inverse_unit.sv]
// 4x4 matrix inverse, signed Q16.16, adjugate method with saturation.
// Loading takes one beat a cycle, a last beat waiting for queue room and queuing the matrix.
// Before the first result the back end idles, copies the 16 elements, runs 78 multiply
// steps and one add, then 64 divide steps; each result needs a multiply (none if singular).
// The back end takes one matrix at a time; the two-entry queue overlaps loading.
// Reset (rst_ni, async, active low) clears the element store and load position to zero.
module matrix4_inverse_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [m4inv_pkg::ElemW-1:0] element_value_i,
  input  logic                               last_element_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [m4inv_pkg::ElemW-1:0] inverse_value_o,
  output logic [1:0]                         out_row_o,
  output logic [1:0]                         out_col_o,
  output logic                               singular_o,
  output logic                               last_result_o
);

  // front to queue: a complete matrix snapshot on each last beat
  m4inv_pkg::q_push_t  q_push;
  logic                q_ready, q_valid, q_pop;
  m4inv_pkg::matrix_t  q_data;

  // back end to the shared multiplier
  m4inv_pkg::mul_req_t mul_req;
  m4inv_pkg::mul_rsp_t mul_rsp;

  // Accept elements and snapshot the store when a matrix is complete, so that
  // loading of the next matrix overlaps inversion of this one.
  m4inv_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .element_value_i (element_value_i),
    .last_element_i  (last_element_i),
    .q_ready_i       (q_ready),
    .q_push_o        (q_push)
  );

  // Hold up to two finished loads while the back end is busy.
  m4inv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  // Single multiplier, shared by the adjugate steps and the final scaling.
  m4inv_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Sequence the adjugate, reciprocal and scaling; drive the output register.
  m4inv_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_data),
    .q_pop_o         (q_pop),
    .mul_req_o       (mul_req),
    .mul_rsp_i       (mul_rsp),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .inverse_value_o (inverse_value_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .singular_o      (singular_o),
    .last_result_o   (last_result_o)
  );

endmodule
